// ===== src/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and request codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Request codes carried in req_type
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_REAR   = 3'd3;
    localparam logic [2:0] REQ_PEEK_FRONT = 3'd4;
    localparam logic [2:0] REQ_PEEK_REAR  = 3'd5;

    localparam int CAP_W  = 9;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Input beat
    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } t_bdq_in;

    // Result beat
    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] data;
        logic                     empty_res;
        logic                     full_res;
    } t_bdq_out;

    // Decision of the pointer unit for one request
    typedef struct packed {
        logic ok;
        logic wr;
        logic rd;
        logic empty_res;
        logic full_res;
    } t_bdq_ctl;

endpackage

// ===== src/bounded_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded deque of signed 32-bit values kept in a ring memory.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while the output is not stalled, and
// returns each result through the memory stage and the output register. Every
// request makes at most one access to the single-port ring memory: a push
// writes its slot and a peek reads its slot, both in the accept cycle, while
// the front index and the element count are updated in registers at the same
// edge; memory reads are registered. Results keep request order. The capacity
// register may be written only while no request is in flight; values above
// DEPTH act as DEPTH, and zero makes every push fail. Entries are never
// cleared, so no startup sweep is needed.
module bounded_double_ended_queue #(
    parameter int DEPTH = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [bdq_pkg::CAP_W-1:0] i_cfg_wr_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  bdq_pkg::t_bdq_in          i_in,
    output logic                      o_valid,
    input  logic                      i_stall,
    output bdq_pkg::t_bdq_out         o_out
);
    import bdq_pkg::*;

    localparam int IW = $clog2(DEPTH);

    logic [CAP_W-1:0]  r_capacity;
    logic              r_s1_valid;
    t_bdq_ctl          r_s1_ctl;
    logic              r_out_valid;
    t_bdq_out          r_out;

    logic              in_fire;
    logic              s1_adv;
    logic [IW-1:0]     addr;
    t_bdq_ctl          ctl;
    logic [DATA_W-1:0] rdata;

    // Handshake: the memory stage moves on when the output register frees up
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_fire = i_valid && !o_stall;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    bdq_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (in_fire),
        .i_req_type (i_in.req_type),
        .i_capacity (r_capacity),
        .o_addr     (addr),
        .o_ctl      (ctl)
    );

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_fire && ctl.wr),
        .i_re    (in_fire && ctl.rd),
        .i_addr  (addr),
        .i_wdata (i_in.value),
        .o_rdata (rdata)
    );

    // Memory stage: hold the decision while the read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_ctl <= ctl;
        end
    end

    // Output register: drop the beat once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.ok        <= r_s1_ctl.ok;
            r_out.data      <= r_s1_ctl.rd ? rdata : '0;
            r_out.empty_res <= r_s1_ctl.empty_res;
            r_out.full_res  <= r_s1_ctl.full_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_stall_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_stall) |-> o_stall)
        else $error("request taken while memory stage blocked");

    a_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> o_valid)
        else $error("memory stage beat lost");

    a_data_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.ok) |-> (o_out.data == '0))
        else $error("failed request returned data");

endmodule

// ===== src/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bdq_ptr.sv =====
// ----------------------------------------------------------------------------
// bdq_ptr
// Front index and element count of the ring, with the ring address and the
// success decision for each request.
// ----------------------------------------------------------------------------
module bdq_ptr #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic [2:0]               i_req_type,
    input  logic [bdq_pkg::CAP_W-1:0] i_capacity,
    output logic [$clog2(DEPTH)-1:0] o_addr,
    output bdq_pkg::t_bdq_ctl        o_ctl
);
    import bdq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    logic [31:0]   cap_w;
    logic [CW-1:0] eff_cap;
    logic          has_room;
    logic          not_empty;
    logic [IW-1:0] front_inc;
    logic [IW-1:0] front_dec;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] last_sum;
    logic [IW-1:0] tail_slot;
    logic [IW-1:0] last_slot;
    logic          ok;
    logic          wr;
    logic          rd;

    // Saturate the capacity at the ring depth
    assign cap_w   = (32'(i_capacity) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(i_capacity);
    assign eff_cap = CW'(cap_w);

    assign has_room  = r_count < eff_cap;
    assign not_empty = r_count != '0;

    // Neighbor slots of the front, wrapping at the depth
    assign front_inc = (r_front == IW'(DEPTH - 1)) ? '0 : r_front + IW'(1);
    assign front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - IW'(1);

    // Slot past the rear and the rear slot itself, sums stay below twice the depth
    assign tail_sum  = SW'(r_front) + SW'(r_count);
    assign last_sum  = tail_sum - SW'(1);
    assign tail_slot = IW'((tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum);
    assign last_slot = IW'((last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum);

    // Decide the request and the next pointer state
    always_comb begin
        ok      = 1'b0;
        wr      = 1'b0;
        rd      = 1'b0;
        o_addr  = r_front;
        n_front = r_front;
        n_count = r_count;
        case (i_req_type)
            REQ_PUSH_FRONT: begin
                ok     = has_room;
                wr     = has_room;
                o_addr = front_dec;
                if (has_room) begin
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            REQ_PUSH_REAR: begin
                ok     = has_room;
                wr     = has_room;
                o_addr = tail_slot;
                if (has_room) begin
                    n_count = r_count + CW'(1);
                end
            end
            REQ_POP_FRONT: begin
                ok = not_empty;
                if (not_empty) begin
                    n_front = front_inc;
                    n_count = r_count - CW'(1);
                end
            end
            REQ_POP_REAR: begin
                ok = not_empty;
                if (not_empty) begin
                    n_count = r_count - CW'(1);
                end
            end
            REQ_PEEK_FRONT: begin
                ok     = not_empty;
                rd     = not_empty;
                o_addr = r_front;
            end
            REQ_PEEK_REAR: begin
                ok     = not_empty;
                rd     = not_empty;
                o_addr = last_slot;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // Flags as they stand after the request
    assign o_ctl.ok        = ok;
    assign o_ctl.wr        = wr;
    assign o_ctl.rd        = rd;
    assign o_ctl.empty_res = n_count == '0;
    assign o_ctl.full_res  = n_count >= eff_cap;

    // Advance front and count on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above ring depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_front) < 32'(DEPTH))
        else $error("front index outside ring");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && wr) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("successful push did not grow the count");

    a_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !ok) |=> ($stable(r_count) && $stable(r_front)))
        else $error("failed request changed the pointers");

endmodule

// ===== dv/bounded_double_ended_queue_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_tb
// Self-checking bench for the bounded double-ended queue.
// ----------------------------------------------------------------------------
// Every accepted request beat is applied to a behavioral deque kept in the
// bench. The expected result beat goes into an in-order queue, and each
// result beat from the block is compared field by field with the oldest
// entry. Directed requests cover empty and full cases, the data extremes,
// unused request codes, a zero capacity and a capacity lowered below the
// element count. Random phases follow under several capacities: one fills
// the ring to its depth and then shrinks it, and one holds the result side
// off long enough to back the block up. Both sides insert random idle
// cycles in some stretches and run at full rate in others.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    // Request codes that the block must ignore
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    localparam int RING_DEPTH = 256;
    localparam int QUIET_LIMIT = 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [CAP_W-1:0]  i_cfg_wr_data;
    logic              i_valid;
    logic              o_stall;
    t_bdq_in           i_in;
    logic              o_valid;
    logic              i_stall;
    t_bdq_out          o_out;

    // Behavioral deque state
    logic signed [DATA_W-1:0] model_slots [RING_DEPTH];
    logic [7:0]               model_front;
    logic [8:0]               model_count;
    logic [CAP_W-1:0]         model_capacity;

    t_bdq_out pending_results [$];

    bit send_idle;
    bit recv_idle;
    int hold_off_left;

    int errors;
    int requests_sent;
    int requests_refused;
    int results_checked;
    int cap_writes;
    int input_stall_cycles;
    int max_count_seen;

    bounded_double_ended_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in          (i_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out         (o_out)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Apply one request to the deque and return the result it should give
    function automatic t_bdq_out predict_deque_op(input logic [2:0] req,
                                                  input logic signed [DATA_W-1:0] val);
        t_bdq_out   r;
        int         limit;
        logic [7:0] slot;
        r = '0;
        limit = (int'(model_capacity) > RING_DEPTH) ? RING_DEPTH : int'(model_capacity);
        case (req)
            REQ_PUSH_FRONT: begin
                if (int'(model_count) < limit) begin
                    model_front = model_front - 8'd1;
                    model_slots[model_front] = val;
                    model_count = model_count + 9'd1;
                    r.ok = 1'b1;
                end
            end
            REQ_PUSH_REAR: begin
                if (int'(model_count) < limit) begin
                    slot = model_front + model_count[7:0];
                    model_slots[slot] = val;
                    model_count = model_count + 9'd1;
                    r.ok = 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (model_count != 9'd0) begin
                    model_front = model_front + 8'd1;
                    model_count = model_count - 9'd1;
                    r.ok = 1'b1;
                end
            end
            REQ_POP_REAR: begin
                if (model_count != 9'd0) begin
                    model_count = model_count - 9'd1;
                    r.ok = 1'b1;
                end
            end
            REQ_PEEK_FRONT: begin
                if (model_count != 9'd0) begin
                    r.data = model_slots[model_front];
                    r.ok = 1'b1;
                end
            end
            REQ_PEEK_REAR: begin
                if (model_count != 9'd0) begin
                    slot = model_front + model_count[7:0] - 8'd1;
                    r.data = model_slots[slot];
                    r.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.empty_res = (model_count == 9'd0);
        r.full_res  = (int'(model_count) >= limit);
        return r;
    endfunction

    // Offer one request beat, hold it until accepted, then log its result
    task automatic send_request(input logic [2:0] req, input logic signed [DATA_W-1:0] val);
        int       gap;
        t_bdq_out want;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in.req_type <= req;
        i_in.value <= val;
        do @(posedge i_clk); while (o_stall);
        want = predict_deque_op(req, val);
        pending_results.push_back(want);
        requests_sent++;
        if (!want.ok) begin
            requests_refused++;
        end
        if (int'(model_count) > max_count_seen) begin
            max_count_seen = int'(model_count);
        end
    endtask

    // Drop valid and wait until every result beat is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= cap;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        model_capacity = cap;
        cap_writes++;
    endtask

    // Random request mix; idling on both sides changes every 25 beats
    task automatic run_random(input int count, input int push_pct, input int pop_pct);
        int                       r;
        logic [2:0]               req;
        logic signed [DATA_W-1:0] val;
        for (int n = 0; n < count; n++) begin
            if (n % 25 == 0) begin
                send_idle = $urandom_range(0, 1);
                recv_idle = $urandom_range(0, 1);
            end
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
                req = $urandom_range(0, 1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
            end else if (r < push_pct + pop_pct) begin
                req = $urandom_range(0, 1) ? REQ_POP_REAR : REQ_POP_FRONT;
            end else if (r < 98) begin
                req = $urandom_range(0, 1) ? REQ_PEEK_REAR : REQ_PEEK_FRONT;
            end else begin
                req = $urandom_range(0, 1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
            end
            case ($urandom_range(0, 15))
                0:       val = 32'sh7FFF_FFFF;
                1:       val = 32'sh8000_0000;
                2:       val = '0;
                default: val = $urandom;
            endcase
            send_request(req, val);
        end
    endtask

    // Empty deque, data extremes, every request code
    task automatic test_empty_and_extremes();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_request(REQ_POP_FRONT, 32'sd5);
        send_request(REQ_POP_REAR, 32'sd6);
        send_request(REQ_PEEK_FRONT, 32'sd7);
        send_request(REQ_PEEK_REAR, 32'sd8);
        send_request(REQ_UNUSED_6, 32'sh7FFF_FFFF);
        send_request(REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(REQ_PUSH_REAR, 32'sh8000_0000);
        send_request(REQ_PEEK_FRONT, 32'sd0);
        send_request(REQ_PEEK_REAR, 32'sd0);
        send_request(REQ_UNUSED_7, -32'sd1);
        send_request(REQ_POP_REAR, 32'sd0);
        send_request(REQ_POP_FRONT, 32'sd0);
    endtask

    // Zero and unit capacity, then a capacity lowered below the count
    task automatic test_capacity_edges();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        write_capacity(9'd0);
        send_request(REQ_PUSH_REAR, 32'sd11);
        send_request(REQ_PEEK_FRONT, 32'sd0);
        write_capacity(9'd1);
        send_request(REQ_PUSH_FRONT, -32'sd1);
        send_request(REQ_PUSH_REAR, 32'sd12);
        send_request(REQ_PEEK_REAR, 32'sd0);
        send_request(REQ_POP_REAR, 32'sd0);
        write_capacity(9'd3);
        send_request(REQ_PUSH_FRONT, 32'sh1234_5678);
        send_request(REQ_PUSH_REAR, 32'shDEAD_BEEF);
        send_request(REQ_PUSH_REAR, 32'sh0F0F_0F0F);
        write_capacity(9'd1);
        send_request(REQ_PUSH_FRONT, 32'sd13);
        send_request(REQ_POP_FRONT, 32'sd0);
        send_request(REQ_POP_REAR, 32'sd0);
        send_request(REQ_PEEK_FRONT, 32'sd0);
        send_request(REQ_POP_FRONT, 32'sd0);
    endtask

    // Small capacities keep the deque bouncing between empty and full
    task automatic test_small_capacities();
        write_capacity(9'd5);
        run_random(30, 50, 30);
        write_capacity(9'd2);
        run_random(20, 45, 35);
    endtask

    // Capacity above depth: fill the whole ring, then shrink below the count
    task automatic test_fill_to_depth();
        write_capacity(9'd511);
        run_random(280, 97, 1);
        write_capacity(9'd100);
        run_random(30, 25, 65);
    endtask

    // Hold the result side off while requests keep coming
    task automatic test_backpressure();
        write_capacity(9'd257);
        send_idle = 1'b0;
        hold_off_left = 200;
        for (int n = 0; n < 30; n++) begin
            send_request($urandom_range(0, 1) ? REQ_PUSH_REAR : REQ_PEEK_FRONT, $urandom);
        end
        write_capacity(9'd256);
        run_random(20, 40, 40);
    endtask

    task automatic compare_field(input string name, input logic signed [DATA_W-1:0] want,
                                 input logic signed [DATA_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                     $time, name, results_checked, want, got);
        end
    endtask

    // Result side: check each beat, then draw the stall for the next one
    initial begin : result_checker
        int       stall_left;
        t_bdq_out want;
        t_bdq_out got;
        stall_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got = o_out;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with no request pending, got ok=%0b data=%0d",
                             $time, got.ok, got.data);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("ok", DATA_W'(want.ok), DATA_W'(got.ok));
                    compare_field("data", want.data, got.data);
                    compare_field("empty_res", DATA_W'(want.empty_res),
                                  DATA_W'(got.empty_res));
                    compare_field("full_res", DATA_W'(want.full_res),
                                  DATA_W'(got.full_res));
                end
                results_checked++;
                stall_left = recv_idle ? $urandom_range(0, 7) : 0;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_valid && o_stall) begin
                input_stall_cycles++;
            end
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                         $time, quiet, pending_results.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_valid = 1'b0;
        i_in = '0;
        hold_off_left = 0;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        model_front = '0;
        model_count = '0;
        model_capacity = CAP_RESET;

        // Hold reset before the tests start
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_extremes();
        test_capacity_edges();
        test_small_capacities();
        test_fill_to_depth();
        test_backpressure();

        // Let the last results come back
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests (%0d refused), %0d results checked, %0d capacity writes",
                 requests_sent, requests_refused, results_checked, cap_writes);
        $display("peak element count %0d, %0d cycles with the request side stalled",
                 max_count_seen, input_stall_cycles);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
